// ----- rtl/core/mcw_pkg.sv -----
`default_nettype none
package mcw_pkg;

    localparam int POS_W          = 30;
    localparam int WORD_W         = 6;
    localparam int CFG_W          = 7;
    localparam int LEN_W          = 31;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 40;
    localparam int DEF_MAX_WORDS  = 64;
    localparam int DEF_WIN_DEPTH  = 4096;
    localparam int CFG_RESET      = 1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] word;
        logic              last;
        logic              push;
    } mcw_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_INC,
        ST_HEAD_RD,
        ST_CNT_RD,
        ST_CNT_CHK,
        ST_FIN
    } mcw_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/mcw_ram.sv -----
`default_nettype none
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/core/mcw_front.sv -----
`default_nettype none
module mcw_front import mcw_pkg::*; #(
    parameter int MAX_WORDS = DEF_MAX_WORDS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    input  wire logic                  s_tlast,
    input  wire logic [CFG_W-1:0]      word_types,
    output mcw_item_t                  q_item,
    output logic                       q_valid,
    input  wire logic                  q_pop
);

    logic              prev_valid_reg;
    logic [POS_W-1:0]  prev_pos_reg;
    logic [WORD_W-1:0] prev_word_reg;
    mcw_item_t         q_mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        q_cnt_reg;

    logic              accept;
    logic [POS_W-1:0]  in_pos;
    logic [WORD_W-1:0] in_word;
    logic              is_repeat;
    logic              in_range;
    mcw_item_t         new_item;

    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_word   = s_tdata[POS_W +: WORD_W];
    assign s_tready  = (q_cnt_reg != 2'd2);
    assign accept    = s_tvalid && s_tready;
    assign is_repeat = prev_valid_reg && (prev_pos_reg == in_pos) && (prev_word_reg == in_word);
    assign in_range  = (CFG_W'(in_word) < word_types) && (32'(in_word) < 32'(MAX_WORDS));

    always_comb begin
        new_item.pos  = in_pos;
        new_item.word = in_word;
        new_item.last = s_tlast;
        new_item.push = !is_repeat && in_range;
    end

    assign q_valid = (q_cnt_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (accept) begin
            q_mem_reg[wr_ptr_reg] <= new_item;
            prev_pos_reg          <= in_pos;
            prev_word_reg         <= in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            q_cnt_reg      <= 2'd0;
        end else begin
            if (accept) begin
                prev_valid_reg <= !s_tlast;
                wr_ptr_reg     <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({accept, q_pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 2'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 2'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/mcw_back.sv -----
`default_nettype none
module mcw_back import mcw_pkg::*; #(
    parameter int MAX_WORDS    = DEF_MAX_WORDS,
    parameter int WINDOW_DEPTH = DEF_WIN_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [CFG_W-1:0]       word_types,
    input  wire mcw_item_t              q_item,
    input  wire logic                   q_valid,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int CNT_W  = FILL_W;
    localparam int WAW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int XW     = (WAW > WORD_W) ? WAW : WORD_W;
    localparam int ST_W   = POS_W + WORD_W;
    localparam int PAD_W  = OUT_TDATA_W - LEN_W - 2;

    function automatic logic [WAW-1:0] word_addr(input logic [WORD_W-1:0] w);
        logic [XW-1:0] x;
        x = XW'(w);
        return x[WAW-1:0];
    endfunction

    mcw_state_t          state_reg, state_next;
    logic [PTR_W-1:0]    head_reg, tail_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [CFG_W-1:0]    distinct_reg;
    logic                covered_reg;
    logic [LEN_W-1:0]    best_reg;
    logic                ovf_reg;
    logic                upd_reg;
    logic [POS_W-1:0]    hp_reg;
    logic [WORD_W-1:0]   hw_reg;
    logic                rd_vld_reg;
    logic [MAX_WORDS-1:0] vld_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic                store_we;
    logic [ST_W-1:0]     store_rdata;
    logic                cnt_we;
    logic [WAW-1:0]      cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata, cnt_cur;
    logic                out_free;
    logic                fin_go;
    logic                full;
    logic [POS_W-1:0]    span;
    logic [LEN_W-1:0]    best_new;
    logic [LEN_W-1:0]    len;

    mcw_ram #(.WIDTH(ST_W), .DEPTH(WINDOW_DEPTH)) u_store (
        .clk   (aclk),
        .we    (store_we),
        .waddr (tail_reg),
        .wdata ({q_item.word, q_item.pos}),
        .raddr (head_reg),
        .rdata (store_rdata)
    );

    mcw_ram #(.WIDTH(CNT_W), .DEPTH(MAX_WORDS)) u_counts (
        .clk   (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    assign cnt_cur  = rd_vld_reg ? cnt_rdata : '0;
    assign full     = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign out_free = !out_valid_reg || m_tready;
    assign fin_go   = !q_item.last || out_free;
    assign span     = q_item.pos - hp_reg;
    assign best_new = (upd_reg && covered_reg && (LEN_W'(span) < best_reg)) ?
                      LEN_W'(span) : best_reg;
    assign len      = covered_reg ? (best_new + LEN_W'(1)) : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign out_valid_next = (state_reg == ST_FIN && fin_go && q_item.last) ? 1'b1 :
                            (m_tready ? 1'b0 : out_valid_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = q_item.push ? ST_PUSH : ST_FIN;
                end
            end
            ST_PUSH:    state_next = full ? ST_FIN : ST_INC;
            ST_INC:     state_next = ST_HEAD_RD;
            ST_HEAD_RD: state_next = ST_CNT_RD;
            ST_CNT_RD:  state_next = (fill_reg > FILL_W'(1)) ? ST_CNT_CHK : ST_FIN;
            ST_CNT_CHK: state_next = (cnt_cur > CNT_W'(1)) ? ST_HEAD_RD : ST_FIN;
            ST_FIN: begin
                if (fin_go) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        store_we  = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = word_addr(q_item.word);
        cnt_wdata = cnt_cur + CNT_W'(1);
        cnt_raddr = word_addr(q_item.word);
        q_pop     = 1'b0;
        unique case (state_reg)
            ST_PUSH:    store_we = !full;
            ST_INC:     cnt_we = 1'b1;
            ST_CNT_RD:  cnt_raddr = word_addr(store_rdata[POS_W +: WORD_W]);
            ST_CNT_CHK: begin
                cnt_waddr = word_addr(hw_reg);
                cnt_wdata = cnt_cur - CNT_W'(1);
                cnt_we    = (cnt_cur > CNT_W'(1));
            end
            ST_FIN:     q_pop = fin_go;
            default:    q_pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_vld_reg <= vld_reg[cnt_raddr];
        if (state_reg == ST_CNT_RD) begin
            hp_reg <= store_rdata[POS_W-1:0];
            hw_reg <= store_rdata[POS_W +: WORD_W];
        end
        if (state_reg == ST_FIN && q_item.last && out_free) begin
            out_data_reg <= {PAD_W'(0), ovf_reg, covered_reg, len};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            distinct_reg  <= '0;
            covered_reg   <= 1'b0;
            best_reg      <= '1;
            ovf_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_PUSH: begin
                    if (full) begin
                        ovf_reg <= 1'b1;
                    end
                end
                ST_INC: begin
                    vld_reg[word_addr(q_item.word)] <= 1'b1;
                    tail_reg <= (tail_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
                    fill_reg <= fill_reg + FILL_W'(1);
                    upd_reg  <= 1'b1;
                    if (cnt_cur == '0) begin
                        distinct_reg <= distinct_reg + CFG_W'(1);
                        if (distinct_reg + CFG_W'(1) == word_types) begin
                            covered_reg <= 1'b1;
                        end
                    end
                end
                ST_CNT_CHK: begin
                    if (cnt_cur > CNT_W'(1)) begin
                        head_reg <= (head_reg == PTR_W'(WINDOW_DEPTH - 1)) ?
                                    '0 : head_reg + PTR_W'(1);
                        fill_reg <= fill_reg - FILL_W'(1);
                    end
                end
                ST_FIN: begin
                    if (fin_go) begin
                        upd_reg <= 1'b0;
                        if (q_item.last) begin
                            head_reg      <= '0;
                            tail_reg      <= '0;
                            fill_reg      <= '0;
                            distinct_reg  <= '0;
                            covered_reg   <= 1'b0;
                            best_reg      <= '1;
                            ovf_reg       <= 1'b0;
                            vld_reg       <= '0;
                        end else begin
                            best_reg <= best_new;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/minimum_covering_window.sv -----
// Minimum covering window.
// Input channel s_*: one beat per (position, word) occurrence of a query,
// positions nondecreasing; s_tlast marks the final occurrence of the query.
// Output channel m_*: one beat per query, sent after the s_tlast beat, with
// the shortest span covering all word types plus one, a found flag and an
// overflow flag. Configuration channel cfg_*: sets word_types; write it only
// while no query is in flight.
// A classifier marks repeated and out-of-range items as not to be stored and
// feeds a two-entry queue; a sequencer behind it updates the window store and
// word counts. Each item passes idle and finish; one to be stored also passes
// push and, unless the window is full, count increment, head read, count read
// and count check (skipped when the window was empty). Each word popped off
// the window front repeats head read, count read and count check, since the
// store and count memory have registered reads. Pops total at most one per
// stored item per query; the result beat is registered as the final item ends.
// Reset clears the query state and sets word_types to 1; the window store is
// not cleared. While m_tready is low the result is held, the sequencer stops
// at the next final item and the queue fills, then s_tready drops.
`default_nettype none
module minimum_covering_window import mcw_pkg::*; #(
    parameter int MAX_WORDS    = DEF_MAX_WORDS,
    parameter int WINDOW_DEPTH = DEF_WIN_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // position[29:0], word[35:30]
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // window_length[30:0], found[31], overflow[32]
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_W-1:0]       cfg_data   // word_types[6:0]
);

    logic [CFG_W-1:0] word_types_reg;
    mcw_item_t        q_item;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_types_reg <= CFG_W'(CFG_RESET);
        end else if (cfg_valid && cfg_ready) begin
            word_types_reg <= cfg_data;
        end
    end

    mcw_front #(.MAX_WORDS(MAX_WORDS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .word_types (word_types_reg),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    mcw_back #(.MAX_WORDS(MAX_WORDS), .WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_types (word_types_reg),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/core/mcw_checker.sv -----
`default_nettype none
module mcw_checker import mcw_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[LEN_W] |-> m_tdata[LEN_W-1:0] == '0)
        else $error("nonzero length without coverage");

    a_found_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[LEN_W] |-> m_tdata[LEN_W-1:0] != '0)
        else $error("zero length with coverage");

endmodule

bind minimum_covering_window mcw_checker u_mcw_checker (.*);
`default_nettype wire
